### hw/rtl/dtpr_pkg.sv
// Shared types, constants and helpers of the digit trie prefix rater.
`default_nettype none

package dtpr_pkg;

    // Default sizing
    localparam int unsigned NODE_COUNT_DEF = 4096;
    localparam int unsigned PLAN_COUNT_DEF = 4;

    // Trie shape
    localparam int unsigned FANOUT    = 10;
    localparam int unsigned DEPTH_MAX = 32;

    // Field widths
    localparam int unsigned RATE_W  = 32;
    localparam int unsigned IV_W    = 16;
    localparam int unsigned TAG_W   = 20;
    localparam int unsigned DUR_W   = 24;
    localparam int unsigned DEPTH_W = 6;
    localparam int unsigned RU_W    = DUR_W + 1;
    localparam int unsigned PROD_W  = RU_W + RATE_W;
    localparam int unsigned CHG_W   = 58;

    // Stream widths
    localparam int unsigned S_TDATA_W = 168;
    localparam int unsigned M_TDATA_W = 200;

    // Commands
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_LOOKUP = 2'd0;
    localparam logic [1:0] STATUS_INSERT = 2'd1;
    localparam logic [1:0] STATUS_FULL   = 2'd2;

    // One node's rating values
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [RATE_W-1:0] connect;
        logic [IV_W-1:0]   interval;
        logic [RATE_W-1:0] vendor;
        logic [RATE_W-1:0] retail;
    } t_node;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STEP,
        ST_START,
        ST_DIV,
        ST_MUL,
        ST_OUT
    } t_state;

    // Root node of a plan: plan modulo the plan count, by repeated subtraction
    function automatic logic [3:0] plan_root(input logic [1:0] plan,
                                             input int unsigned count);
        logic [4:0] r;
        r = {3'b000, plan};
        for (int i = 0; i < 4; i++) begin
            if (r >= 5'(count)) begin
                r = r - 5'(count);
            end
        end
        return r[3:0];
    endfunction

endpackage

`default_nettype wire

### hw/rtl/digit_trie_prefix_rater.sv
// Top level of the digit trie prefix rater: trie sequencer, node stores and output register.
`default_nettype none

// Ten-way decimal digit tries, one per rate plan, sharing one node store. After
// reset the block sweeps both stores, one node per cycle, and takes no input
// transfer until that is done. Each digit then goes through two states: one
// reads the child row and the node values of the current node, the next
// follows or creates the child and writes back the row, and no new digit is
// taken until both are done. The last digit of an insert loads its result into
// the output register in that second state, once the register is free. The
// last digit of a lookup reads the node reached and runs the bit-serial
// remainder unit and one multiply. A result waits in the output register; a new
// digit is taken while it waits.
module digit_trie_prefix_rater
    import dtpr_pkg::*;
#(
    parameter int unsigned NODE_COUNT = NODE_COUNT_DEF,
    parameter int unsigned PLAN_COUNT = PLAN_COUNT_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    // plan, digit, retail_rate, vendor_rate, interval_seconds, connect_fee,
    // route_tag, duration_seconds, zero fill
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    input  wire logic                 i_s_tlast,
    // cmd
    input  wire logic                 i_s_tuser,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    // match_tag, match_depth, out_retail, out_vendor, out_interval,
    // out_connect, charge, zero fill
    output logic [M_TDATA_W-1:0]      o_m_tdata,
    // status
    output logic [1:0]                o_m_tuser
);

    localparam int unsigned AW = $clog2(NODE_COUNT);
    localparam int unsigned NW = AW + 1;
    localparam int unsigned RW = FANOUT * AW;

    // Stores
    logic [RW-1:0] link_mem [NODE_COUNT];
    t_node         node_mem [NODE_COUNT];

    // Store ports
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          link_we;
    logic [AW-1:0] link_waddr;
    logic [RW-1:0] link_wdata;
    logic          node_we;
    logic [AW-1:0] node_waddr;
    t_node         node_wdata;
    logic [RW-1:0] r_link_q;
    t_node         r_node_q;

    // Control registers
    t_state           r_state,     n_state;
    logic [AW-1:0]    r_clr_addr,  n_clr_addr;
    logic [AW-1:0]    r_walk_node, n_walk_node;
    logic             r_stopped,   n_stopped;
    logic [DEPTH_W-1:0] r_depth,   n_depth;
    logic             r_ovf,       n_ovf;
    logic [NW-1:0]    r_next_free, n_next_free;
    logic             r_out_valid, n_out_valid;

    // Item registers
    logic              r_cmd,      n_cmd;
    logic [3:0]        r_digit,    n_digit;
    logic              r_last,     n_last;
    t_node             r_item,     n_item;
    logic [DUR_W-1:0]  r_duration, n_duration;

    // Charge datapath
    logic [RU_W-1:0]   r_ru,       n_ru;
    logic [PROD_W-1:0] r_prod,     n_prod;

    // Output register
    logic [1:0]         r_out_status, n_out_status;
    logic [DEPTH_W-1:0] r_out_depth,  n_out_depth;
    t_node              r_out_node,   n_out_node;
    logic [CHG_W-1:0]   r_out_charge, n_out_charge;

    // Remainder unit
    logic            div_start;
    logic            div_done;
    logic [IV_W-1:0] div_rem;
    logic [IV_W-1:0] adj;

    // Step helpers
    logic          s_accept;
    logic          out_free;
    logic          fresh;
    logic [AW-1:0] child;
    logic [3:0]    in_digit;

    dtpr_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_duration),
        .i_divisor  (r_node_q.interval),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign fresh      = (r_depth == '0) && !r_stopped && !r_ovf;
    assign child      = r_link_q[r_digit*AW +: AW];
    assign in_digit   = (i_s_tdata[5:2] > 4'd9) ? 4'd0 : i_s_tdata[5:2];
    assign adj        = (div_rem == '0) ? '0 : r_node_q.interval - div_rem;

    // Next state, store accesses and results
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_walk_node  = r_walk_node;
        n_stopped    = r_stopped;
        n_depth      = r_depth;
        n_ovf        = r_ovf;
        n_next_free  = r_next_free;
        n_cmd        = r_cmd;
        n_digit      = r_digit;
        n_last       = r_last;
        n_item       = r_item;
        n_duration   = r_duration;
        n_ru         = r_ru;
        n_prod       = r_prod;
        n_out_status = r_out_status;
        n_out_depth  = r_out_depth;
        n_out_node   = r_out_node;
        n_out_charge = r_out_charge;
        n_out_valid  = r_out_valid && !i_m_tready;
        rd_en        = 1'b0;
        rd_addr      = r_walk_node;
        link_we      = 1'b0;
        link_waddr   = r_walk_node;
        link_wdata   = r_link_q;
        node_we      = 1'b0;
        node_waddr   = r_walk_node;
        node_wdata   = r_node_q;
        div_start    = 1'b0;

        case (r_state)
            // Sweep both stores to their reset contents
            ST_CLEAR: begin
                link_we             = 1'b1;
                link_waddr          = r_clr_addr;
                link_wdata          = '0;
                node_we             = 1'b1;
                node_waddr          = r_clr_addr;
                node_wdata          = '0;
                node_wdata.interval = IV_W'(1);
                n_clr_addr          = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(NODE_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end

            // Take a digit and read the current node
            ST_IDLE: begin
                if (s_accept) begin
                    n_cmd              = i_s_tuser;
                    n_digit            = in_digit;
                    n_last             = i_s_tlast;
                    n_item.retail      = i_s_tdata[37:6];
                    n_item.vendor      = i_s_tdata[69:38];
                    n_item.interval    = i_s_tdata[85:70];
                    n_item.connect     = i_s_tdata[117:86];
                    n_item.tag         = i_s_tdata[137:118];
                    n_duration         = i_s_tdata[161:138];
                    if (fresh) begin
                        n_walk_node = AW'(plan_root(i_s_tdata[1:0], PLAN_COUNT));
                    end
                    rd_en   = 1'b1;
                    rd_addr = n_walk_node;
                    n_state = ST_STEP;
                end
            end

            // Follow or create the child
            ST_STEP: begin
                if (r_cmd == CMD_LOOKUP) begin
                    if (!r_stopped) begin
                        if (child != '0) begin
                            n_walk_node = child;
                            if (r_depth < DEPTH_W'(DEPTH_MAX)) begin
                                n_depth = r_depth + 1'b1;
                            end
                        end else begin
                            n_stopped = 1'b1;
                        end
                    end
                    if (r_last) begin
                        rd_en   = 1'b1;
                        rd_addr = n_walk_node;
                        n_state = ST_START;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else if (!r_last || out_free) begin
                    if (!r_ovf) begin
                        if (child != '0) begin
                            n_walk_node = child;
                            if (r_depth < DEPTH_W'(DEPTH_MAX)) begin
                                n_depth = r_depth + 1'b1;
                            end
                        end else if (r_next_free < NW'(NODE_COUNT)) begin
                            link_we = 1'b1;
                            link_wdata[r_digit*AW +: AW] = r_next_free[AW-1:0];
                            node_we     = 1'b1;
                            node_waddr  = r_next_free[AW-1:0];
                            n_walk_node = r_next_free[AW-1:0];
                            n_next_free = r_next_free + 1'b1;
                            if (r_depth < DEPTH_W'(DEPTH_MAX)) begin
                                n_depth = r_depth + 1'b1;
                            end
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                    if (r_last) begin
                        n_out_valid  = 1'b1;
                        n_out_depth  = n_depth;
                        n_out_charge = '0;
                        if (n_ovf) begin
                            n_out_status = STATUS_FULL;
                            n_out_node   = '0;
                        end else begin
                            // Store the route; this overrides any copy above
                            node_we    = 1'b1;
                            node_waddr = n_walk_node;
                            node_wdata = r_item;
                            if (r_item.interval == '0) begin
                                node_wdata.interval = IV_W'(1);
                            end
                            n_out_status = STATUS_INSERT;
                            n_out_node   = node_wdata;
                        end
                        n_walk_node = '0;
                        n_stopped   = 1'b0;
                        n_depth     = '0;
                        n_ovf       = 1'b0;
                    end
                    n_state = ST_IDLE;
                end
            end

            // Node of the lookup is read: start the remainder
            ST_START: begin
                div_start = 1'b1;
                n_state   = ST_DIV;
            end

            // Round the call length up to whole intervals
            ST_DIV: begin
                if (div_done) begin
                    n_ru    = {1'b0, r_duration} + RU_W'(adj);
                    n_state = ST_MUL;
                end
            end

            ST_MUL: begin
                n_prod  = r_ru * r_node_q.retail;
                n_state = ST_OUT;
            end

            // Hand over the lookup result and end the walk
            ST_OUT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = STATUS_LOOKUP;
                    n_out_depth  = r_depth;
                    n_out_node   = r_node_q;
                    n_out_charge = CHG_W'(r_prod) + CHG_W'(r_node_q.connect);
                    n_walk_node  = '0;
                    n_stopped    = 1'b0;
                    n_depth      = '0;
                    n_ovf        = 1'b0;
                    n_state      = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_walk_node <= '0;
            r_stopped   <= 1'b0;
            r_depth     <= '0;
            r_ovf       <= 1'b0;
            r_next_free <= NW'(PLAN_COUNT);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_walk_node <= n_walk_node;
            r_stopped   <= n_stopped;
            r_depth     <= n_depth;
            r_ovf       <= n_ovf;
            r_next_free <= n_next_free;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_digit      <= n_digit;
        r_last       <= n_last;
        r_item       <= n_item;
        r_duration   <= n_duration;
        r_ru         <= n_ru;
        r_prod       <= n_prod;
        r_out_status <= n_out_status;
        r_out_depth  <= n_out_depth;
        r_out_node   <= n_out_node;
        r_out_charge <= n_out_charge;
    end

    // Child row store
    always_ff @(posedge i_clk) begin
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (rd_en) begin
            r_link_q <= link_mem[rd_addr];
        end
    end

    // Node value store
    always_ff @(posedge i_clk) begin
        if (node_we) begin
            node_mem[node_waddr] <= node_wdata;
        end
        if (rd_en) begin
            r_node_q <= node_mem[rd_addr];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {4'b0000, r_out_charge, r_out_node.connect, r_out_node.interval,
                         r_out_node.vendor, r_out_node.retail, r_out_depth,
                         r_out_node.tag};

`ifndef NO_ASSERTIONS
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free <= NW'(NODE_COUNT))
        else $error("node allocation ran past the store");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(DEPTH_MAX))
        else $error("walk depth above saturation");

    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == ST_DIV)
        else $error("remainder finished outside its wait state");

    a_no_read_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> !node_we)
        else $error("node store read and written in one cycle");

    a_lookup_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_START |=> r_state == ST_DIV)
        else $error("lookup did not start the remainder");
`endif

endmodule

`default_nettype wire

### hw/rtl/dtpr_rem.sv
// Bit-serial remainder unit: call length modulo billing interval.
`default_nettype none

module dtpr_rem
    import dtpr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DUR_W-1:0] i_dividend,
    input  wire logic [IV_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [IV_W-1:0]       o_rem
);

    localparam int unsigned CW = $clog2(DUR_W);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DUR_W-1:0] r_dvd;
    logic [IV_W-1:0]  r_rem;
    logic [IV_W-1:0]  r_div;
    logic [IV_W:0]    trial;
    logic [IV_W:0]    diff;
    logic [IV_W-1:0]  n_rem;

    // Shift in one dividend bit and subtract where it fits
    always_comb begin
        trial = {r_rem, r_dvd[DUR_W-1]};
        diff  = trial - {1'b0, r_div};
        n_rem = (trial >= {1'b0, r_div}) ? diff[IV_W-1:0] : trial[IV_W-1:0];
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DUR_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DUR_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire
